>>> sv/cpot_pkg.sv
// Shared constants and types for the cell pair opening test.
package cpot_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int          ANGLE_W     = 16;
    localparam logic [15:0] ANGLE_RESET = 16'd8192;
    localparam int          ANGLE_SQ_W  = 2 * ANGLE_W;
    localparam int          ANGLE_SHIFT = 28;

    typedef enum logic [1:0] {
        DEC_OPEN   = 2'd0,
        DEC_ACCEPT = 2'd1,
        DEC_ABORT  = 2'd2
    } t_decision;

    typedef enum logic [1:0] {
        REG_ANGLE  = 2'd0,
        REG_MODE   = 2'd1,
        REG_CUTOFF = 2'd2,
        REG_SPLIT  = 2'd3
    } t_reg_idx;

endpackage

>>> sv/cell_pair_opening_test_top.sv
// Cell pair opening test: six-stage pipeline, one pair per cycle.
// Throughput: one pair per cycle; a stall holds only the stages that are full.
// Reset clears all stage valids and loads the register defaults
// (angle 0.5, long/short off, both radii all ones).
module cell_pair_opening_test_top #(
    parameter int COORD_WIDTH = cpot_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = cpot_pkg::FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [COORD_WIDTH-2:0]                  i_first_width_x,
    input  logic [COORD_WIDTH-2:0]                  i_first_width_y,
    input  logic [COORD_WIDTH-2:0]                  i_first_width_z,
    input  logic [COORD_WIDTH-2:0]                  i_second_width_x,
    input  logic [COORD_WIDTH-2:0]                  i_second_width_y,
    input  logic [COORD_WIDTH-2:0]                  i_second_width_z,
    input  logic signed [COORD_WIDTH-1:0]           i_offset_x,
    input  logic signed [COORD_WIDTH-1:0]           i_offset_y,
    input  logic signed [COORD_WIDTH-1:0]           i_offset_z,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [1:0]                              o_decision,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [((COORD_WIDTH > 33) ? 5 : 4)-1:0]  paddr,
    input  logic [((COORD_WIDTH > 33) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 33) ? 64 : 32)-1:0] prdata,
    output logic                                    pready
);
    import cpot_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int WW   = CW - 1;
    localparam int PDW  = (CW > 33) ? 64 : 32;
    localparam int AS   = (CW > 33) ? 3 : 2;
    localparam int SW   = CW;
    localparam int GW   = CW + 2;
    localparam int AW   = CW + 1;
    localparam int SSW  = CW + 4;
    localparam int GMW  = CW + 2;
    localparam int W4W  = 2 * CW + 2;
    localparam int D4W  = 2 * CW + 3;
    localparam int GQW  = 2 * GMW;
    localparam int RQW  = 2 * CW;
    localparam int DL   = CW + 2;
    localparam int DH   = D4W - DL;
    localparam int PLW  = ANGLE_SQ_W + DL;
    localparam int PHW  = ANGLE_SQ_W + DH;
    localparam int CMPW = 2 * CW + 35;
    localparam longint EPS2 =
        2 * longint'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

    // ---------------- configuration ----------------
    logic [ANGLE_W-1:0]    r_angle;
    logic                  r_mode;
    logic [WW-1:0]         r_cutoff;
    logic [WW-1:0]         r_split;
    logic [ANGLE_SQ_W-1:0] r_angle_sq;
    logic [RQW-1:0]        r_cutoff_sq4;
    logic [RQW-1:0]        r_split_sq4;
    logic                  n_cfg_wr;
    t_reg_idx              n_reg_idx;

    assign pready    = 1'b1;
    assign n_cfg_wr  = psel & penable & pwrite;
    assign n_reg_idx = t_reg_idx'(paddr[AS+1:AS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle  <= ANGLE_RESET;
            r_mode   <= 1'b0;
            r_cutoff <= '1;
            r_split  <= '1;
        end else if (n_cfg_wr) begin
            unique case (n_reg_idx)
                REG_ANGLE:  r_angle  <= pwdata[ANGLE_W-1:0];
                REG_MODE:   r_mode   <= pwdata[0];
                REG_CUTOFF: r_cutoff <= pwdata[WW-1:0];
                REG_SPLIT:  r_split  <= pwdata[WW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (n_reg_idx)
            REG_ANGLE:  prdata = PDW'(r_angle);
            REG_MODE:   prdata = PDW'(r_mode);
            REG_CUTOFF: prdata = PDW'(r_cutoff);
            REG_SPLIT:  prdata = PDW'(r_split);
            default:    prdata = '0;
        endcase
    end

    // derived squares of the configuration registers, registered; used by stage 4
    always_ff @(posedge i_clk) begin
        r_angle_sq   <= ANGLE_SQ_W'(r_angle) * ANGLE_SQ_W'(r_angle);
        r_cutoff_sq4 <= (RQW'(r_cutoff) * RQW'(r_cutoff)) << 2;
        r_split_sq4  <= (RQW'(r_split) * RQW'(r_split)) << 2;
    end

    // ---------------- flow control ----------------
    logic [6:1] r_v;
    logic [6:1] n_rdy;

    always_comb begin
        n_rdy[6] = !r_v[6] || !i_stall;
        for (int k = 5; k >= 1; k--) begin
            n_rdy[k] = !r_v[k] || n_rdy[k+1];
        end
    end

    assign o_stall = !n_rdy[1];
    assign o_valid = r_v[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_rdy[1]) r_v[1] <= i_valid;
            for (int k = 2; k <= 6; k++) begin
                if (n_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // ---------------- stage 1: width sums and doubled gaps ----------------
    logic [WW-1:0]        n_wi   [3];
    logic [WW-1:0]        n_wj   [3];
    logic signed [CW-1:0] n_off  [3];
    logic [CW-1:0]        n_mag  [3];
    logic [SW-1:0]        n_wsum [3];
    logic signed [GW-1:0] n_gap  [3];
    logic [SW-1:0]        r_s1_wsum [3];
    logic signed [GW-1:0] r_s1_gap  [3];

    always_comb begin
        n_wi[0]  = i_first_width_x;
        n_wi[1]  = i_first_width_y;
        n_wi[2]  = i_first_width_z;
        n_wj[0]  = i_second_width_x;
        n_wj[1]  = i_second_width_y;
        n_wj[2]  = i_second_width_z;
        n_off[0] = i_offset_x;
        n_off[1] = i_offset_y;
        n_off[2] = i_offset_z;
        for (int k = 0; k < 3; k++) begin
            n_wsum[k] = {1'b0, n_wi[k]} + {1'b0, n_wj[k]};
            n_mag[k]  = n_off[k][CW-1] ? (~n_off[k] + 1'b1) : n_off[k];
            n_gap[k]  = $signed({1'b0, n_mag[k], 1'b0} - {2'b00, n_wsum[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[1]) begin
            r_s1_wsum <= n_wsum;
            r_s1_gap  <= n_gap;
        end
    end

    // ---------------- stage 2: per-axis squares, gap sum ----------------
    logic [AW-1:0]         n_abs [3];
    logic [2*SW-1:0]       r_s2_wsq [3];
    logic [2*AW-1:0]       r_s2_gsq [3];
    logic signed [SSW-1:0] r_s2_gsum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_abs[k] = r_s1_gap[k][GW-1] ? AW'(-r_s1_gap[k]) : AW'(r_s1_gap[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[2]) begin
            for (int k = 0; k < 3; k++) begin
                r_s2_wsq[k] <= (2*SW)'(r_s1_wsum[k]) * (2*SW)'(r_s1_wsum[k]);
                r_s2_gsq[k] <= (2*AW)'(n_abs[k]) * (2*AW)'(n_abs[k]);
            end
            r_s2_gsum <= SSW'(r_s1_gap[0]) + SSW'(r_s1_gap[1]) + SSW'(r_s1_gap[2]);
        end
    end

    // ---------------- stage 3: sums, neighbor test, gap sum squared ----------------
    logic [GMW-1:0] n_gmag;
    logic [W4W-1:0] r_s3_w4;
    logic [D4W-1:0] r_s3_d4;
    logic [GQW-1:0] r_s3_gg;
    logic           r_s3_nb;

    assign n_gmag = r_s2_gsum[GMW-1:0];

    always_ff @(posedge i_clk) begin
        if (n_rdy[3]) begin
            r_s3_w4 <= W4W'(r_s2_wsq[0]) + W4W'(r_s2_wsq[1]) + W4W'(r_s2_wsq[2]);
            r_s3_d4 <= D4W'(r_s2_gsq[0]) + D4W'(r_s2_gsq[1]) + D4W'(r_s2_gsq[2]);
            r_s3_gg <= GQW'(n_gmag) * GQW'(n_gmag);
            r_s3_nb <= (longint'(r_s2_gsum) < EPS2);
        end
    end

    // ---------------- stage 4: radius and shape tests, theta^2 * D partials ----------------
    logic           n_elong;
    logic           n_abort;
    logic           n_split;
    logic [PLW-1:0] r_s4_pl;
    logic [PHW-1:0] r_s4_ph;
    logic [W4W-1:0] r_s4_w4;
    logic           r_s4_tenth;
    logic           r_s4_abort;
    logic           r_s4_nb;

    assign n_elong = ({r_s3_d4, 1'b0} <= r_s3_gg);
    assign n_abort = r_mode && (r_s3_d4 > D4W'(r_cutoff_sq4));
    assign n_split = r_mode && (r_s3_d4 > D4W'(r_split_sq4));

    always_ff @(posedge i_clk) begin
        if (n_rdy[4]) begin
            r_s4_pl    <= PLW'(r_angle_sq) * PLW'(r_s3_d4[DL-1:0]);
            r_s4_ph    <= PHW'(r_angle_sq) * PHW'(r_s3_d4[D4W-1:DL]);
            r_s4_w4    <= r_s3_w4;
            r_s4_tenth <= n_elong | n_split;
            r_s4_abort <= n_abort;
            r_s4_nb    <= r_s3_nb;
        end
    end

    // ---------------- stage 5: assemble both sides ----------------
    logic [W4W+3:0]  n_w4x;
    logic [CMPW-1:0] r_s5_lhs;
    logic [CMPW-1:0] r_s5_rhs;
    logic            r_s5_abort;
    logic            r_s5_nb;

    assign n_w4x = r_s4_tenth ? ((W4W+4)'(r_s4_w4) << 3) + ((W4W+4)'(r_s4_w4) << 1)
                              : (W4W+4)'(r_s4_w4);

    always_ff @(posedge i_clk) begin
        if (n_rdy[5]) begin
            r_s5_lhs   <= CMPW'(n_w4x) << ANGLE_SHIFT;
            r_s5_rhs   <= CMPW'(r_s4_pl) + (CMPW'(r_s4_ph) << DL);
            r_s5_abort <= r_s4_abort;
            r_s5_nb    <= r_s4_nb;
        end
    end

    // ---------------- stage 6: decision ----------------
    t_decision n_dec;
    t_decision r_s6_dec;

    always_comb begin
        if (r_s5_nb) begin
            n_dec = DEC_OPEN;
        end else if (r_s5_abort) begin
            n_dec = DEC_ABORT;
        end else if (r_s5_lhs < r_s5_rhs) begin
            n_dec = DEC_ACCEPT;
        end else begin
            n_dec = DEC_OPEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[6]) begin
            r_s6_dec <= n_dec;
        end
    end

    assign o_decision = r_s6_dec;

endmodule
